// ===== sv/shsm_pkg.sv =====
// Package for the half-step stepper mover: beat types, command and register codes,
// and the coil pattern table. No dependencies.
package shsm_pkg;

    localparam int ANGLE_W = 9;
    localparam int Q8_W    = 16;
    localparam int STEPS_W = 17;
    localparam int PHASE_W = 3;
    localparam int COILS_W = 4;
    localparam int PROD_W  = ANGLE_W + Q8_W;
    localparam int CMD_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLOSE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_OPEN  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_DEG = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE   = 1'd1;

    localparam logic [Q8_W-1:0]    STEPS_PER_DEG_RESET = 16'd2913;
    localparam logic [ANGLE_W-1:0] START_ANGLE_RESET   = 9'd0;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [ANGLE_W-1:0] target_angle;
    } in_item_t;

    typedef struct packed {
        logic [COILS_W-1:0] coils;
        logic               last_step;
    } out_item_t;

    // Half-step coil pattern for each phase.
    function automatic logic [COILS_W-1:0] coil_pattern(input logic [PHASE_W-1:0] phase);
        logic [COILS_W-1:0] pat;
        case (phase)
            3'd0:    pat = 4'h8;
            3'd1:    pat = 4'hC;
            3'd2:    pat = 4'h4;
            3'd3:    pat = 4'h6;
            3'd4:    pat = 4'h2;
            3'd5:    pat = 4'h3;
            3'd6:    pat = 4'h1;
            default: pat = 4'h9;
        endcase
        return pat;
    endfunction

endpackage

// ===== sv/shsm_move_calc.sv =====
// Step count for a move: floor(|target - current| * steps_per_degree_q8 / 256).
// Depends on shsm_pkg.
module shsm_move_calc (
    input  logic [shsm_pkg::ANGLE_W-1:0] current_angle,
    input  logic [shsm_pkg::ANGLE_W-1:0] target_angle,
    input  logic [shsm_pkg::Q8_W-1:0]    steps_per_degree_q8,
    output logic [shsm_pkg::STEPS_W-1:0] step_count
);
    import shsm_pkg::*;

    logic [ANGLE_W-1:0] diff;
    logic [PROD_W-1:0]  prod;

    always_comb
    begin
        if (target_angle >= current_angle)
        begin
            diff = target_angle - current_angle;
        end
        else
        begin
            diff = current_angle - target_angle;
        end
        prod = PROD_W'(diff) * PROD_W'(steps_per_degree_q8);
        // Dropping the eight fraction bits truncates toward zero.
        step_count = prod[PROD_W-1:8];
    end

endmodule

// ===== sv/shsm_out_stage.sv =====
// Result register with valid/stall handshake toward the consumer.
// Depends on shsm_pkg.
module shsm_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  shsm_pkg::out_item_t load_item,
    output logic                free,
    output logic                out_valid,
    input  logic                out_stall,
    output shsm_pkg::out_item_t out_data
);
    import shsm_pkg::*;

    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_item_reg;

    // The register can take a new beat when it is empty or its beat leaves now.
    assign free = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_item_reg <= load_item;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule

// ===== sv/stepper_half_step_mover.sv =====
// Half-step mover for a four-coil unipolar stepper.
// A tick's result beat passes through the input register, then the result register, and
// waits while the result register is full. Throughput: one beat per cycle while out_stall
// does not hold the result register. Reset: pipeline empty, phase 0, no steps left,
// steps_per_degree 2913, start and current angle 0.
module stepper_half_step_mover (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  shsm_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output shsm_pkg::out_item_t                 out_data,
    input  logic                                cfg_we,
    input  logic [shsm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [shsm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import shsm_pkg::*;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    in_item_t           s1_item_reg;
    logic [Q8_W-1:0]    q8_reg;
    logic [ANGLE_W-1:0] cur_angle_reg;
    logic [PHASE_W-1:0] phase_reg;
    logic               count_up_reg;
    logic [STEPS_W-1:0] steps_left_reg;

    logic               in_accept;
    logic               is_move;
    logic               has_result;
    logic               fire;
    logic               out_free;
    logic [STEPS_W-1:0] step_count;
    out_item_t          result;

    shsm_move_calc u_move_calc (
        .current_angle       (cur_angle_reg),
        .target_angle        (s1_item_reg.target_angle),
        .steps_per_degree_q8 (q8_reg),
        .step_count          (step_count)
    );

    always_comb
    begin
        is_move    = s1_item_reg.cmd == CMD_CLOSE || s1_item_reg.cmd == CMD_OPEN;
        has_result = s1_item_reg.cmd == CMD_TICK && steps_left_reg != '0;
        // Beats without a result never wait on the result register.
        fire       = s1_valid_reg && (!has_result || out_free);
        in_stall   = s1_valid_reg && !fire;
        in_accept  = in_valid && !in_stall;

        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (fire)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        result.coils     = coil_pattern(phase_reg);
        result.last_step = steps_left_reg == STEPS_W'(1);
    end

    shsm_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire && has_result),
        .load_item (result),
        .free      (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_item_reg <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            q8_reg          <= STEPS_PER_DEG_RESET;
            cur_angle_reg   <= START_ANGLE_RESET;
            phase_reg       <= '0;
            count_up_reg    <= 1'b0;
            steps_left_reg  <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;

            if (fire && is_move)
            begin
                steps_left_reg <= step_count;
                cur_angle_reg  <= s1_item_reg.target_angle;
                count_up_reg   <= s1_item_reg.cmd == CMD_CLOSE;
            end
            else if (fire && has_result)
            begin
                steps_left_reg <= steps_left_reg - STEPS_W'(1);
                if (count_up_reg)
                begin
                    phase_reg <= phase_reg + PHASE_W'(1);
                end
                else
                begin
                    phase_reg <= phase_reg - PHASE_W'(1);
                end
            end

            // Writing the start angle also presets the current position.
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_STEPS_PER_DEG:
                    begin
                        q8_reg <= cfg_data;
                    end
                    CFG_START_ANGLE:
                    begin
                        cur_angle_reg <= cfg_data[ANGLE_W-1:0];
                    end
                    default:
                    begin
                        q8_reg <= q8_reg;
                    end
                endcase
            end
        end
    end

endmodule

// ===== tb/sv/stepper_half_step_mover_tb.sv =====
// Self-checking testbench for the half-step stepper mover: random valid/stall traffic on
// both beat channels, register writes between phases, and an in-line step predictor.
// Depends on shsm_pkg (sv/shsm_pkg.sv) and the stepper_half_step_mover RTL.
module stepper_half_step_mover_tb;
    import shsm_pkg::*;

    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;

    // Tracks angle, phase and remaining steps, and queues the coil beats that ticks produce.
    class step_scoreboard;
        logic [Q8_W-1:0]    steps_q8;
        logic [ANGLE_W-1:0] start_ang;
        logic [ANGLE_W-1:0] cur_ang;
        logic [PHASE_W-1:0] phase;
        logic               up;
        logic [STEPS_W-1:0] steps_left;
        logic [COILS_W-1:0] coil_seq [8];
        out_item_t          pending [$];
        int                 errors;
        int                 n_beats;
        int                 n_results;
        int                 n_ends;

        function new();
            coil_seq   = '{4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1, 4'h9};
            steps_q8   = STEPS_PER_DEG_RESET;
            start_ang  = START_ANGLE_RESET;
            cur_ang    = START_ANGLE_RESET;
            phase      = '0;
            up         = 1'b0;
            steps_left = '0;
            errors     = 0;
            n_beats    = 0;
            n_results  = 0;
            n_ends     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_STEPS_PER_DEG: steps_q8 = data;
                CFG_START_ANGLE:
                begin
                    // Writing the start angle also presets the current position.
                    start_ang = data[ANGLE_W-1:0];
                    cur_ang   = start_ang;
                end
                default: ;
            endcase
        endfunction

        function void note_input(in_item_t it);
            logic [ANGLE_W-1:0] diff;
            logic [PROD_W-1:0]  prod;
            out_item_t          exp_beat;
            n_beats++;
            if (it.cmd == CMD_CLOSE || it.cmd == CMD_OPEN)
            begin
                diff = (it.target_angle >= cur_ang) ? it.target_angle - cur_ang
                                                    : cur_ang - it.target_angle;
                prod       = diff * steps_q8;
                steps_left = prod[PROD_W-1:8];
                cur_ang    = it.target_angle;
                up         = (it.cmd == CMD_CLOSE);
            end
            else if (it.cmd == CMD_TICK && steps_left != 0)
            begin
                exp_beat.coils     = coil_seq[phase];
                exp_beat.last_step = (steps_left == 1);
                pending.push_back(exp_beat);
                steps_left--;
                phase = up ? phase + 3'd1 : phase - 3'd1;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp_beat;
            if (pending.size() == 0)
            begin
                $error("result beat with nothing expected: coils %h last_step %b",
                       got.coils, got.last_step);
                errors++;
                return;
            end
            exp_beat = pending.pop_front();
            n_results++;
            if (exp_beat.last_step)
                n_ends++;
            if (got.coils !== exp_beat.coils)
            begin
                $error("coils: expected %h, got %h", exp_beat.coils, got.coils);
                errors++;
            end
            if (got.last_step !== exp_beat.last_step)
            begin
                $error("last_step: expected %b, got %b", exp_beat.last_step, got.last_step);
                errors++;
            end
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    step_scoreboard sb = new();
    bit tx_quiet     = 1'b0;
    bit rx_quiet     = 1'b0;
    bit hold_request = 1'b0;
    int settings     = 0;

    stepper_half_step_mover dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly back-to-back, sometimes a short gap, now and then a long pause.
    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic send_beat(logic [CMD_W-1:0] cmd, logic [ANGLE_W-1:0] angle);
        in_item_t it;
        int       gap;
        it.cmd          = cmd;
        it.target_angle = angle;
        gap = pick_gap(tx_quiet);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        sb.note_input(it);
    endtask

    task automatic move_and_ticks(logic [CMD_W-1:0] cmd, logic [ANGLE_W-1:0] angle,
                                  int ticks);
        send_beat(cmd, angle);
        repeat (ticks) send_beat(CMD_TICK, ANGLE_W'($urandom_range(0, 511)));
    endtask

    // Drain every pending step beat, then give a trailing move time to leave the pipeline.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, data);
        @(posedge clk);
    endtask

    task automatic apply_setting(logic [Q8_W-1:0] q8, logic [ANGLE_W-1:0] angle);
        logic [CFG_DATA_W-ANGLE_W-1:0] junk;
        junk = (CFG_DATA_W-ANGLE_W)'($urandom_range(0, 127));
        settle();
        write_reg(CFG_STEPS_PER_DEG, q8);
        write_reg(CFG_START_ANGLE, {junk, angle});
        settings++;
    endtask

    // Mostly a move followed by enough ticks to finish it, often to a nearby angle so
    // that moves end; some moves get cut short, and one pass in ten sends a single random beat.
    task automatic run_random(int n);
        int                 done;
        int                 r;
        int                 ticks;
        logic [ANGLE_W-1:0] tgt;
        logic [ANGLE_W-1:0] offset;
        logic [CMD_W-1:0]   cmd;
        done = 0;
        while (done < n)
        begin
            tx_quiet = ($urandom_range(0, 7) == 0);
            rx_quiet = ($urandom_range(0, 7) == 0);
            r = $urandom_range(0, 9);
            if (r == 0)
            begin
                cmd = CMD_W'($urandom_range(0, 3));
                send_beat(cmd, ANGLE_W'($urandom_range(0, 511)));
                if (cmd != CMD_NONE)
                    done++;
            end
            else
            begin
                cmd = $urandom_range(0, 1) ? CMD_CLOSE : CMD_OPEN;
                if (r < 8)
                begin
                    offset = ANGLE_W'($urandom_range(0, 6));
                    tgt    = sb.cur_ang + offset - 9'd3;
                end
                else
                    tgt = ANGLE_W'($urandom_range(0, 511));
                send_beat(cmd, tgt);
                if (sb.steps_left + 2 <= 40)
                    ticks = sb.steps_left + $urandom_range(0, 2);
                else
                    ticks = $urandom_range(1, 40);
                repeat (ticks) send_beat(CMD_TICK, ANGLE_W'($urandom_range(0, 511)));
                done += 1 + ticks;
            end
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    // Result side: checks each accepted beat and decides the stall for the next cycle.
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && !out_stall)
                sb.check_result(out_data);
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES - 1;
                out_stall   <= 1'b1;
            end
            else if (!rx_quiet && $urandom_range(0, 3) == 0)
            begin
                stall_left = pick_gap(1'b0);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: idle tick, unused code, a short close run and an interrupted open.
        send_beat(CMD_TICK, 9'd0);
        send_beat(CMD_NONE, 9'h1FF);
        move_and_ticks(CMD_CLOSE, 9'd1, 12);
        move_and_ticks(CMD_OPEN, 9'd0, 3);
        move_and_ticks(CMD_OPEN, 9'd0, 1);

        // Long move while the result side holds off, so the block backs up.
        send_beat(CMD_CLOSE, 9'd180);
        hold_request = 1'b1;
        tx_quiet     = 1'b1;
        repeat (40) send_beat(CMD_TICK, ANGLE_W'($urandom_range(0, 511)));
        tx_quiet = 1'b0;
        run_random(70);

        // One step per degree: a single-step move flags its only beat as the last.
        apply_setting(16'd256, 9'd360);
        move_and_ticks(CMD_CLOSE, 9'd361, 2);
        move_and_ticks(CMD_OPEN, 9'd359, 3);
        run_random(70);

        // Largest factor and angle: the longest possible step count.
        apply_setting(16'hFFFF, 9'd511);
        move_and_ticks(CMD_OPEN, 9'd0, 3);
        move_and_ticks(CMD_CLOSE, 9'd511, 2);
        run_random(60);

        // Zero factor: every move yields no steps.
        apply_setting(16'd0, 9'd0);
        move_and_ticks(CMD_CLOSE, 9'd360, 1);
        run_random(50);

        apply_setting(16'd1, ANGLE_W'($urandom_range(0, 360)));
        run_random(60);

        repeat (2)
        begin
            apply_setting(Q8_W'($urandom_range(1, 1024)), ANGLE_W'($urandom_range(0, 360)));
            run_random(60);
        end

        settle();
        $display("Sent %0d command beats over %0d register settings.", sb.n_beats, settings);
        $display("Checked %0d coil beats, %0d of them ending a move.", sb.n_results, sb.n_ends);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout: %0d coil beats still outstanding", sb.pending.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
